/* hdl/tpr_pkg.sv */
// Package: shared types and constants for the tachometer block.
package tpr_pkg;

   typedef enum logic [1:0] {
      CMD_CAPTURE = 2'd0,
      CMD_CHECK   = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_NONE    = 2'd3
   } cmd_type;

   localparam logic [1:0] ST_NO_SIGNAL = 2'd0;
   localparam logic [1:0] ST_RUNNING   = 2'd1;
   localparam logic [1:0] ST_INVALID   = 2'd2;

   localparam logic [15:0] CARRY_LIMIT = 16'h8000;
   localparam logic [31:0] MIN_PERIOD  = 32'd100;
   localparam logic [31:0] MAX_PERIOD  = 32'd1000000;
   localparam logic [31:0] FREQ_NUM    = 32'd1000000;
   localparam logic [31:0] RPM_NUM     = 32'd60000000;
   localparam logic [16:0] RPM_CAP     = 17'd100000;

   localparam logic [7:0]  PPR_RESET     = 8'd1;
   localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [0:0] REG_PPR     = 1'd0;
   localparam logic [0:0] REG_TIMEOUT = 1'd1;

   // decoded item passed from front to back
   typedef struct packed {
      cmd_type     cmd;
      logic [31:0] stamp;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      logic [16:0] rpm;
      logic [13:0] freq_hz;
      logic [1:0]  status;
      logic [31:0] good_count;
      logic [31:0] bad_count;
   } result_type;

endpackage

/* hdl/tpr_if.sv */
// Interfaces: request and response channels.
interface tpr_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] capture_ticks;
   logic [15:0] timer_wraps;
   logic        update_pending;
   logic [31:0] now_ms;
   modport source (output valid, cmd, capture_ticks, timer_wraps, update_pending, now_ms,
                   input ready);
   modport sink   (input valid, cmd, capture_ticks, timer_wraps, update_pending, now_ms,
                   output ready);
endinterface

interface tpr_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] rpm;
   logic [13:0] freq_hz;
   logic [1:0]  status;
   logic [31:0] good_count;
   logic [31:0] bad_count;
   modport source (output valid, rpm, freq_hz, status, good_count, bad_count,
                   input ready);
   modport sink   (input valid, rpm, freq_hz, status, good_count, bad_count,
                   output ready);
endinterface

/* hdl/tpr_front.sv */
// Front end: builds timestamps, decodes command, queues items for the back end.
module tpr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_cmd,
   input  logic [15:0]         req_capture_ticks,
   input  logic [15:0]         req_timer_wraps,
   input  logic                req_update_pending,
   input  logic [31:0]         req_now_ms,
   output logic                item_valid,
   input  logic                item_ready,
   output tpr_pkg::item_type   item
);
   tpr_pkg::item_type q_ff [tpr_pkg::QUEUE_DEPTH];
   logic [0:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;
   logic [15:0] hi;
   tpr_pkg::item_type new_item;

   assign req_ready  = (cnt_ff != 2'(tpr_pkg::QUEUE_DEPTH));
   assign push       = req_valid && req_ready;
   assign item_valid = (cnt_ff != 2'd0);
   assign pop        = item_valid && item_ready;
   assign item       = q_ff[rd_ff];

   always_comb begin
      hi = req_timer_wraps;
      if (req_update_pending && (req_capture_ticks < tpr_pkg::CARRY_LIMIT)) begin
         hi = req_timer_wraps + 16'd1;
      end
      new_item.cmd    = tpr_pkg::cmd_type'(req_cmd);
      new_item.stamp  = {hi, req_capture_ticks};
      new_item.now_ms = req_now_ms;
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= new_item;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(tpr_pkg::QUEUE_DEPTH)) else $error("queue count overrun");
   a_full_noready: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'(tpr_pkg::QUEUE_DEPTH)) |-> !req_ready) else $error("full queue ready");
   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (cnt_ff == $past(cnt_ff) - 2'd1)) else $error("pop count");
`endif
endmodule

/* hdl/tpr_div.sv */
// Radix-2 restoring divider, 32-bit quotient, one bit per cycle.
module tpr_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [39:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);
   logic [39:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [39:0] dvs_ff;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [40:0] trial;

   assign done     = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial = {rem_ff, quo_ff[31]} - {1'b0, dvs_ff};
         if (!trial[40]) begin
            rem_in = trial[39:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[38:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      if (start) begin
         dvs_ff <= divisor;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end
endmodule

/* hdl/tpr_back.sv */
// Back end: state update, period checks, frequency and rpm via shared divider.
module tpr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          ppr,
   input  logic [15:0]         timeout_ms,
   input  logic                item_valid,
   output logic                item_ready,
   input  tpr_pkg::item_type   item,
   output logic                res_valid,
   input  logic                res_ready,
   output tpr_pkg::result_type res
);
   typedef enum logic [2:0] {
      S_IDLE, S_FREQ_WAIT, S_RPM_MUL, S_RPM_WAIT, S_OUT
   } state_type;

   state_type   state_ff;
   logic [31:0] last_ts_ff, last_ms_ff, good_ff, bad_ff, period_ff;
   logic        first_ff;
   logic [16:0] rpm_ff;
   logic [13:0] freq_ff;
   logic [1:0]  stat_ff;
   logic [39:0] prod_ff;
   logic        div_start;
   logic [31:0] div_num;
   logic [39:0] div_den;
   logic        div_done;
   logic [31:0] div_q;
   logic [31:0] period;
   logic [7:0]  ppr_eff;

   assign period     = item.stamp - last_ts_ff;
   assign ppr_eff    = (ppr == 8'd0) ? 8'd1 : ppr;
   assign item_ready = (state_ff == S_IDLE);
   assign res_valid  = (state_ff == S_OUT);
   assign res        = '{rpm: rpm_ff, freq_hz: freq_ff, status: stat_ff,
                         good_count: good_ff, bad_count: bad_ff};

   tpr_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_num),
      .divisor(div_den), .done(div_done), .quotient(div_q)
   );

   always_comb begin
      div_start = 1'b0;
      div_num   = tpr_pkg::FREQ_NUM;
      div_den   = {8'd0, period};
      if (state_ff == S_IDLE && item_valid && item.cmd == tpr_pkg::CMD_CAPTURE && !first_ff
          && period >= tpr_pkg::MIN_PERIOD && period <= tpr_pkg::MAX_PERIOD) begin
         div_start = 1'b1;
      end else if (state_ff == S_RPM_MUL) begin
         div_start = 1'b1;
         div_num   = tpr_pkg::RPM_NUM;
         div_den   = prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         last_ts_ff <= '0;
         first_ff   <= 1'b1;
         last_ms_ff <= '0;
         rpm_ff     <= '0;
         freq_ff    <= '0;
         stat_ff    <= tpr_pkg::ST_NO_SIGNAL;
         good_ff    <= '0;
         bad_ff     <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (item_valid) begin
                  state_ff <= S_OUT;
                  unique case (item.cmd)
                     tpr_pkg::CMD_CAPTURE: begin
                        last_ts_ff <= item.stamp;
                        if (first_ff) begin
                           first_ff <= 1'b0;
                           stat_ff  <= tpr_pkg::ST_NO_SIGNAL;
                        end else if (period < tpr_pkg::MIN_PERIOD) begin
                           bad_ff  <= bad_ff + 32'd1;
                           stat_ff <= tpr_pkg::ST_INVALID;
                        end else if (period > tpr_pkg::MAX_PERIOD) begin
                           bad_ff  <= bad_ff + 32'd1;
                           rpm_ff  <= '0;
                           freq_ff <= '0;
                           stat_ff <= tpr_pkg::ST_INVALID;
                        end else begin
                           period_ff  <= period;
                           last_ms_ff <= item.now_ms;
                           stat_ff    <= tpr_pkg::ST_RUNNING;
                           good_ff    <= good_ff + 32'd1;
                           state_ff   <= S_FREQ_WAIT;
                        end
                     end
                     tpr_pkg::CMD_CHECK: begin
                        if (last_ms_ff == 32'd0 ||
                            (item.now_ms - last_ms_ff) > {16'd0, timeout_ms}) begin
                           rpm_ff  <= '0;
                           freq_ff <= '0;
                           stat_ff <= tpr_pkg::ST_NO_SIGNAL;
                        end
                     end
                     tpr_pkg::CMD_CLEAR: begin
                        last_ts_ff <= '0;
                        first_ff   <= 1'b1;
                        last_ms_ff <= '0;
                        rpm_ff     <= '0;
                        freq_ff    <= '0;
                        stat_ff    <= tpr_pkg::ST_NO_SIGNAL;
                        good_ff    <= '0;
                        bad_ff     <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            S_FREQ_WAIT: begin
               if (div_done) begin
                  freq_ff  <= div_q[13:0];
                  state_ff <= S_RPM_MUL;
               end
            end
            S_RPM_MUL: state_ff <= S_RPM_WAIT;
            S_RPM_WAIT: begin
               if (div_done) begin
                  rpm_ff   <= (div_q > {15'd0, tpr_pkg::RPM_CAP}) ? tpr_pkg::RPM_CAP
                                                                  : div_q[16:0];
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (res_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_FREQ_WAIT && div_done) begin
         prod_ff <= period_ff * {32'd0, ppr_eff};
      end
   end

`ifndef SYNTHESIS
   a_stat_range: assert property (@(posedge clock) disable iff (reset)
      stat_ff != 2'd3) else $error("bad status code");
   a_rpm_cap: assert property (@(posedge clock) disable iff (reset)
      rpm_ff <= tpr_pkg::RPM_CAP) else $error("rpm over cap");
   a_good_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FREQ_WAIT) |-> (stat_ff == tpr_pkg::ST_RUNNING))
      else $error("status not running in divide");
`endif
endmodule

/* hdl/tachometer_period_rpm.sv */
// Tachometer top level: turns timer-capture beats into frequency and rpm.
// Each request beat yields exactly one response beat showing the state after the
// command. Capture beats form a 32-bit microsecond stamp; a good period (100 us to
// 1 s) runs two 32-step divisions through one shared radix-2 divider, so a good
// capture holds the back end through both divisions, while checks, clears, rejected
// periods and the first capture skip the divider. A two-entry queue sits between
// the decode front and the compute back so requests are taken while a result waits.
// Registers: 0x0 pulses_per_rotation (8 bits, reset 1; zero acts as 1),
// 0x4 no_signal_timeout_ms (16 bits, reset 1000). Write only while idle.
module tachometer_period_rpm (
   input  logic        clock,
   input  logic        reset,
   tpr_req_if.sink     req,
   tpr_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [7:0]  ppr_ff;
   logic [15:0] timeout_ff;
   logic        item_valid, item_ready, res_valid;
   tpr_pkg::item_type   item;
   tpr_pkg::result_type res_ff, res;
   logic        out_valid_ff;
   logic        csr_wr;
   logic [0:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr  = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx = csr_paddr[2];

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'd0) begin
         unique case (csr_idx)
            tpr_pkg::REG_PPR:     csr_prdata = {24'd0, ppr_ff};
            tpr_pkg::REG_TIMEOUT: csr_prdata = {16'd0, timeout_ff};
            default:              csr_prdata = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppr_ff     <= tpr_pkg::PPR_RESET;
         timeout_ff <= tpr_pkg::TIMEOUT_RESET;
      end else if (csr_wr && csr_paddr[1:0] == 2'd0) begin
         if (csr_idx == tpr_pkg::REG_PPR) ppr_ff <= csr_pwdata[7:0];
         else timeout_ff <= csr_pwdata[15:0];
      end
   end

   tpr_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_cmd(req.cmd),
      .req_capture_ticks(req.capture_ticks), .req_timer_wraps(req.timer_wraps),
      .req_update_pending(req.update_pending), .req_now_ms(req.now_ms),
      .item_valid(item_valid), .item_ready(item_ready), .item(item)
   );

   logic res_take;
   assign res_take = !out_valid_ff || rsp.ready;

   tpr_back u_back (
      .clock(clock), .reset(reset), .ppr(ppr_ff), .timeout_ms(timeout_ff),
      .item_valid(item_valid), .item_ready(item_ready), .item(item),
      .res_valid(res_valid), .res_ready(res_take), .res(res)
   );

   // output register
   always_ff @(posedge clock) begin
      if (res_valid && res_take) res_ff <= res;
      if (reset) out_valid_ff <= 1'b0;
      else if (res_take) out_valid_ff <= res_valid;
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.rpm        = res_ff.rpm;
   assign rsp.freq_hz    = res_ff.freq_hz;
   assign rsp.status     = res_ff.status;
   assign rsp.good_count = res_ff.good_count;
   assign rsp.bad_count  = res_ff.bad_count;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.good_count)))
      else $error("response dropped");
   a_ppr_reset: assert property (@(posedge clock)
      $past(reset) |-> (ppr_ff == tpr_pkg::PPR_RESET)) else $error("ppr reset");
   a_load: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_take) |=> out_valid_ff) else $error("result not loaded");
`endif
endmodule

/* tb/tpr_checker.sv */
// Checker: watches request and response beats, predicts tachometer results, compares.
module tpr_checker (
   input  logic        clock,
   input  logic        reset,
   tpr_req_if.sink     req_mon,
   tpr_rsp_if.sink     rsp_mon,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          failures,
   output int          pending
);

   tpr_pkg::result_type results_due[$];
   logic [7:0]  ppr;
   logic [15:0] timeout_ms;
   logic [31:0] prev_stamp, pulse_ms;
   logic        first_wait;
   tpr_pkg::result_type tach;

   function automatic void clear_tach();
      prev_stamp = '0;
      first_wait = 1'b1;
      pulse_ms   = '0;
      tach       = '0;
   endfunction

   task automatic predict_beat(input logic [1:0] cmd, input logic [15:0] cap,
                               input logic [15:0] ovf, input logic upd,
                               input logic [31:0] now);
      logic [15:0] hi;
      logic [31:0] stamp, period;
      logic [63:0] q;
      logic [31:0] eff_ppr;
      hi = ovf;
      if (upd && cap < tpr_pkg::CARRY_LIMIT) hi = hi + 16'd1;
      stamp = {hi, cap};
      case (cmd)
         tpr_pkg::CMD_CAPTURE: begin
            if (first_wait) begin
               prev_stamp = stamp;
               first_wait = 1'b0;
               tach.status = tpr_pkg::ST_NO_SIGNAL;
            end else begin
               period = stamp - prev_stamp;
               prev_stamp = stamp;
               if (period < tpr_pkg::MIN_PERIOD) begin
                  tach.bad_count++;
                  tach.status = tpr_pkg::ST_INVALID;
               end else if (period > tpr_pkg::MAX_PERIOD) begin
                  tach.bad_count++;
                  tach.rpm = '0;
                  tach.freq_hz = '0;
                  tach.status = tpr_pkg::ST_INVALID;
               end else begin
                  tach.freq_hz = 14'(tpr_pkg::FREQ_NUM / period);
                  eff_ppr = (ppr == 0) ? 32'd1 : {24'd0, ppr};
                  q = 64'(tpr_pkg::RPM_NUM) / (64'(period) * 64'(eff_ppr));
                  tach.rpm = (q > tpr_pkg::RPM_CAP) ? tpr_pkg::RPM_CAP : 17'(q);
                  pulse_ms = now;
                  tach.status = tpr_pkg::ST_RUNNING;
                  tach.good_count++;
               end
            end
         end
         tpr_pkg::CMD_CHECK: begin
            if (pulse_ms == 0 || (now - pulse_ms) > {16'd0, timeout_ms}) begin
               tach.rpm = '0;
               tach.freq_hz = '0;
               tach.status = tpr_pkg::ST_NO_SIGNAL;
            end
         end
         tpr_pkg::CMD_CLEAR: clear_tach();
         default: ;
      endcase
      results_due.push_back(tach);
   endtask

   always @(posedge clock) begin
      tpr_pkg::result_type got, want;
      if (reset) begin
         ppr = tpr_pkg::PPR_RESET;
         timeout_ms = tpr_pkg::TIMEOUT_RESET;
         clear_tach();
         results_due.delete();
         failures = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == tpr_pkg::REG_TIMEOUT) timeout_ms = csr_pwdata[15:0];
            else ppr = csr_pwdata[7:0];
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{rsp_mon.rpm, rsp_mon.freq_hz, rsp_mon.status,
                    rsp_mon.good_count, rsp_mon.bad_count};
            if (results_due.size() == 0) begin
               failures++;
               if (failures <= 10) $display("unexpected response beat %p", got);
            end else begin
               want = results_due.pop_front();
               if (got !== want) begin
                  failures++;
                  if (failures <= 10) $display("mismatch: expected %p actual %p", want, got);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_beat(req_mon.cmd, req_mon.capture_ticks, req_mon.timer_wraps,
                         req_mon.update_pending, req_mon.now_ms);
      end
      pending = results_due.size();
   end

endmodule

/* tb/tb.sv */
// Testbench top: drives request beats and register writes, gives the verdict.
module tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          failures, pending;
   int          sent;
   int          idle_pct, stall_pct;

   tpr_req_if req ();
   tpr_rsp_if rsp ();

   tachometer_period_rpm DUT (
      .clock, .reset, .req(req.sink), .rsp(rsp.source),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   tpr_checker u_checker (
      .clock, .reset, .req_mon(req.sink), .rsp_mon(rsp.sink),
      .csr_psel, .csr_penable, .csr_pwrite, .csr_pready, .csr_paddr, .csr_pwdata,
      .failures, .pending
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.cmd = tpr_pkg::CMD_NONE;
      req.capture_ticks = '0;
      req.timer_wraps = '0;
      req.update_pending = 1'b0;
      req.now_ms = '0;
      rsp.ready = 1'b0;
   end

   // receiver: random stall at the percentage of the current phase
   always @(posedge clock)
      rsp.ready <= ($urandom_range(99) >= stall_pct);

   // Emulated pulse train; stamp is the running 32-bit microsecond time.
   logic [31:0] stamp_us, tick_ms;

   // one request beat; sender gap drawn before it, valid held until accepted
   task automatic send_beat(input logic [1:0] cmd, input logic [15:0] cap,
                            input logic [15:0] ovf, input logic upd,
                            input logic [31:0] now);
      if ($urandom_range(99) < idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.cmd <= cmd;
      req.capture_ticks <= cap;
      req.timer_wraps <= ovf;
      req.update_pending <= upd;
      req.now_ms <= now;
      do @(posedge clock); while (!req.ready);
      sent++;
   endtask

   // capture of an absolute stamp; sometimes shows the overflow as still pending
   task automatic send_stamp(input logic [31:0] st, input logic [31:0] now);
      logic [15:0] ovf;
      logic        upd;
      upd = 1'b0;
      ovf = st[31:16];
      if (st[15:0] < 16'h8000 && $urandom_range(3) == 0) begin
         upd = 1'b1;
         ovf = ovf - 16'd1;
      end else if (st[15:0] >= 16'h8000 && $urandom_range(3) == 0) begin
         upd = 1'b1; // pending flag ignored for late captures
      end
      send_beat(tpr_pkg::CMD_CAPTURE, st[15:0], ovf, upd, now);
   endtask

   // sender holds off until every expected result has come back
   task automatic wait_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic drain();
      wait_results();
      repeat (80) @(posedge clock); // nothing left in flight
   endtask

   // APB write: setup then access, only while idle
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int n);
      int k, sel;
      logic [31:0] per;
      for (k = 0; k < n; k++) begin
         sel = $urandom_range(99);
         if (sel < 65) begin
            // mostly good periods, sometimes short or long ones
            case ($urandom_range(9))
               0:       per = $urandom_range(99);
               1:       per = $urandom_range(32'd1000001, 32'd5000000);
               2:       per = $urandom_range(100, 400);
               3:       per = $urandom_range(999000, 1000000);
               default: per = $urandom_range(100, 60000);
            endcase
            stamp_us += per;
            tick_ms  += per / 1000 + $urandom_range(1);
            send_stamp(stamp_us, tick_ms);
         end else if (sel < 85) begin
            tick_ms += $urandom_range(0, 1500);
            send_beat(tpr_pkg::CMD_CHECK, 16'($urandom), 16'($urandom), 1'($urandom),
                      tick_ms);
         end else if (sel < 90) begin
            send_beat(tpr_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom),
                      $urandom);
         end else if (sel < 93) begin
            send_beat(tpr_pkg::CMD_NONE, 16'($urandom), 16'($urandom), 1'($urandom),
                      $urandom);
         end else begin
            // noise: arbitrary capture or check content
            send_beat(2'($urandom_range(1)), 16'($urandom), 16'($urandom), 1'($urandom),
                      $urandom);
         end
      end
   endtask

   initial begin
      int ph;
      sent = 0; idle_pct = 0; stall_pct = 0;
      stamp_us = 32'h0001_0000; tick_ms = 32'd5;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: check before any pulse, first capture, short/long/good periods,
      // wrap of the stamp, rpm cap, tick zero, unused code, clear
      send_beat(tpr_pkg::CMD_CHECK, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
      send_beat(tpr_pkg::CMD_CAPTURE, 16'h0000, 16'h0000, 1'b0, 32'd0);
      send_beat(tpr_pkg::CMD_CAPTURE, 16'd99, 16'h0000, 1'b0, 32'd1);   // short period
      send_beat(tpr_pkg::CMD_CAPTURE, 16'd199, 16'h0000, 1'b0, 32'd0);  // good at tick zero
      send_beat(tpr_pkg::CMD_CHECK, 16'd0, 16'd0, 1'b0, 32'd2);          // still "no pulse"
      send_beat(tpr_pkg::CMD_CAPTURE, 16'h7FFF, 16'h000F, 1'b1, 32'd10); // carry, long
      send_beat(tpr_pkg::CMD_CAPTURE, 16'h8000, 16'h0010, 1'b1, 32'd11); // no carry, short
      send_beat(tpr_pkg::CMD_CAPTURE, 16'hFFFF, 16'hFFFF, 1'b0, 32'hFFFF_FFF0);
      send_beat(tpr_pkg::CMD_CAPTURE, 16'h0063, 16'hFFFF, 1'b1, 32'hFFFF_FFF8); // wraps to 100
      send_beat(tpr_pkg::CMD_CHECK, 16'd0, 16'd0, 1'b0, 32'd500);        // wrapping delta ok
      send_beat(tpr_pkg::CMD_CHECK, 16'd0, 16'd0, 1'b0, 32'd2000);       // timeout
      send_beat(tpr_pkg::CMD_NONE, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
      send_beat(tpr_pkg::CMD_CAPTURE, 16'h4240, 16'h000F, 1'b0, 32'd3000);
      send_beat(tpr_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
      send_beat(tpr_pkg::CMD_CAPTURE, 16'd0, 16'd0, 1'b0, 32'd1);
      send_beat(tpr_pkg::CMD_CAPTURE, 16'h4240, 16'h000F, 1'b0, 32'd4000); // exactly 1 s
      drain();

      // register settings, extremes included; zero pulses per rotation acts as one
      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin csr_write(3'h0, 32'd255); csr_write(3'h4, 32'd1);     end
            1: begin csr_write(3'h0, 32'd0);   csr_write(3'h4, 32'd65535); end
            2: begin csr_write(3'h0, 32'd4);   csr_write(3'h4, 32'd50);    end
            3: begin csr_write(3'h0, 32'd1);   csr_write(3'h4, 32'd1000);  end
            4: begin csr_write(3'h0, 32'($urandom_range(1, 255)));
                     csr_write(3'h4, 32'($urandom_range(1, 65535)));       end
            default: begin csr_write(3'h0, 32'd2); csr_write(3'h4, 32'd300); end
         endcase
         // idling phases: none, sender only, receiver only, both
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 57; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 57; end
            default: begin idle_pct = 13; stall_pct = 13; end
         endcase
         random_phase(160);
         wait_results();
         random_phase(160);
         drain();
      end
      idle_pct = 0; stall_pct = 0;

      $display("covered %0d request beats over six register settings", sent);
      $display("idling mixes: none, sender, receiver, both; clears, checks, bad periods");
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout");
      $display("status: fail");
      $finish;
   end

endmodule
